// ===== src/calclk_pkg.sv =====
package calclk_pkg;

	// Field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int WDAY_W   = 3;
	localparam int CENT_W   = 7;
	localparam int PROD_W   = 27;
	localparam int SUM_W    = 10;

	// Calendar limits
	localparam logic [YEAR_W-1:0]   YEAR_MAX       = 14'd9999;
	localparam logic [YEAR_W-1:0]   YEAR_RESET     = 14'd2000;
	localparam logic [YEAR_W-1:0]   YEAR_OFFSET    = 14'd400;
	localparam logic [MONTH_W-1:0]  MONTH_JAN      = 4'd1;
	localparam logic [MONTH_W-1:0]  MONTH_FEB      = 4'd2;
	localparam logic [MONTH_W-1:0]  MONTH_MAR      = 4'd3;
	localparam logic [MONTH_W-1:0]  MONTH_APR      = 4'd4;
	localparam logic [MONTH_W-1:0]  MONTH_JUN      = 4'd6;
	localparam logic [MONTH_W-1:0]  MONTH_SEP      = 4'd9;
	localparam logic [MONTH_W-1:0]  MONTH_NOV      = 4'd11;
	localparam logic [MONTH_W-1:0]  MONTH_DEC      = 4'd12;
	localparam logic [DAY_W-1:0]    DAY_FIRST      = 5'd1;
	localparam logic [HOUR_W-1:0]   HOUR_MAX       = 5'd23;
	localparam logic [HOUR_W:0]     HOURS_PER_DAY  = 6'd24;
	localparam logic [MINUTE_W-1:0] MINUTE_MAX     = 6'd59;
	localparam logic [MINUTE_W:0]   MINS_PER_HOUR  = 7'd60;
	localparam logic [WDAY_W-1:0]   WDAY_RESET     = 3'd6;
	localparam logic [3:0]          DAYS_PER_WEEK  = 4'd7;

	// Division by 100 through a reciprocal: exact for years up to 10399
	localparam logic [12:0]         DIV100_MUL     = 13'd5243;
	localparam int                  DIV100_SHIFT   = 19;
	localparam logic [YEAR_W-1:0]   CENTURY        = 14'd100;

	// Bit k set when minute k is a multiple of five
	function automatic logic [63:0] build_five_mask();
		logic [63:0] mask;
		mask = '0;
		for (int k = 0; k < 60; k += 5) begin
			mask[k] = 1'b1;
		end
		return mask;
	endfunction

	localparam logic [63:0] FIVE_MASK = build_five_mask();

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
	} date_t;

	function automatic logic [DAY_W-1:0] month_length(
		input logic [MONTH_W-1:0] month,
		input logic               leap
	);
		logic [DAY_W-1:0] len;
		len = 5'd31;
		if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
		    month == MONTH_NOV) begin
			len = 5'd30;
		end else if (month == MONTH_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end
		return len;
	endfunction

	// (2*m + 3*(m+1)/5) mod 7, Jan and Feb taken as months 13 and 14
	function automatic logic [2:0] month_wday_offset(input logic [MONTH_W-1:0] month);
		logic [2:0] ofs;
		case (month)
			4'd1:    ofs = 3'd6;
			4'd2:    ofs = 3'd2;
			4'd3:    ofs = 3'd1;
			4'd4:    ofs = 3'd4;
			4'd5:    ofs = 3'd6;
			4'd6:    ofs = 3'd2;
			4'd7:    ofs = 3'd4;
			4'd8:    ofs = 3'd0;
			4'd9:    ofs = 3'd3;
			4'd10:   ofs = 3'd5;
			4'd11:   ofs = 3'd1;
			4'd12:   ofs = 3'd3;
			default: ofs = 3'd0;
		endcase
		return ofs;
	endfunction

endpackage

// ===== src/calendar_clock_counter_core.sv =====
// Calendar clock counter. Each input transaction either advances the clock by
// 0 to 59 minutes (cmd 0, larger values count as 59) or loads a date and time
// (cmd 1, fields clamped into range; a day past the month end is kept until the
// next day change). Every transaction returns one result: the date and time
// after it, the day of week (1 Monday to 7 Sunday, Gregorian rule), a flag for
// a crossed midnight and a flag for a minute that is a multiple of five after
// an advance. February has 29 days in any year divisible by 4; year 9999 wraps
// to 0. After reset the clock reads 2000-01-01 00:00, Saturday. Throughput is
// one transaction per clock while out_stall is low; a result passes the date
// stage and the day-of-week pipeline (century split, then mod-7 sum).
module calendar_clock_counter_core
	import calclk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [MINUTE_W-1:0] minutes_to_add,
	input  logic [YEAR_W-1:0]   set_year,
	input  logic [MONTH_W-1:0]  set_month,
	input  logic [DAY_W-1:0]    set_day,
	input  logic [HOUR_W-1:0]   set_hour,
	input  logic [MINUTE_W-1:0] set_minute,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [YEAR_W-1:0]   cur_year,
	output logic [MONTH_W-1:0]  cur_month,
	output logic [DAY_W-1:0]    cur_day,
	output logic [HOUR_W-1:0]   cur_hour,
	output logic [MINUTE_W-1:0] cur_minute,
	output logic [WDAY_W-1:0]   weekday,
	output logic                day_rolled,
	output logic                five_minute_mark
);

	date_t state_q;
	date_t next_date;
	logic  rolled_c;
	logic  mark_c;
	logic  in_fire;

	logic  valid_s1, valid_s2, valid_s3;
	logic  en_s1, en_s2, en_s3;
	date_t date_s1, date_s2, date_s3;
	logic  rolled_s1, rolled_s2, rolled_s3;
	logic  mark_s1, mark_s2, mark_s3;
	logic [YEAR_W-1:0] yadj_s2;
	logic [CENT_W-1:0] cent_s2;
	logic [WDAY_W-1:0] weekday_s3;

	logic [YEAR_W-1:0] yadj_c;
	logic [PROD_W-1:0] cent_prod;
	logic [6:0]        rem_c;
	logic [SUM_W-1:0]  dow_sum;
	logic [4:0]        fold1;
	logic [3:0]        fold2;
	logic [2:0]        dow_c;

	// Pipeline flow control: a stage moves when the next one can take it
	assign en_s3    = !valid_s3 || !out_stall;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;
	assign in_fire  = in_valid && en_s1;

	// Next date and time, load or advance with carries
	always_comb begin
		logic [MINUTE_W-1:0] add_sat;
		logic [MINUTE_W:0]   min_sum;
		logic [HOUR_W:0]     hour_inc;
		logic [DAY_W:0]      day_inc;
		logic [MONTH_W-1:0]  month_inc;
		next_date = state_q;
		rolled_c  = 1'b0;
		mark_c    = 1'b0;
		add_sat   = '0;
		min_sum   = '0;
		hour_inc  = '0;
		day_inc   = '0;
		month_inc = '0;
		if (cmd) begin
			next_date.year   = (set_year > YEAR_MAX) ? YEAR_MAX : set_year;
			next_date.month  = (set_month < MONTH_JAN) ? MONTH_JAN :
			                   (set_month > MONTH_DEC) ? MONTH_DEC : set_month;
			next_date.day    = (set_day < DAY_FIRST) ? DAY_FIRST : set_day;
			next_date.hour   = (set_hour > HOUR_MAX) ? HOUR_MAX : set_hour;
			next_date.minute = (set_minute > MINUTE_MAX) ? MINUTE_MAX : set_minute;
		end else begin
			add_sat = (minutes_to_add > MINUTE_MAX) ? MINUTE_MAX : minutes_to_add;
			min_sum = {1'b0, state_q.minute} + {1'b0, add_sat};
			if (min_sum >= MINS_PER_HOUR) begin
				next_date.minute = MINUTE_W'(min_sum - MINS_PER_HOUR);
				hour_inc = {1'b0, state_q.hour} + 6'd1;
				if (hour_inc >= HOURS_PER_DAY) begin
					next_date.hour = '0;
					rolled_c = 1'b1;
					// Day change, with month and year rollover
					day_inc = {1'b0, state_q.day} + 6'd1;
					if (day_inc > {1'b0, month_length(state_q.month,
					                                  state_q.year[1:0] == 2'd0)}) begin
						next_date.day = DAY_FIRST;
						month_inc = state_q.month + 4'd1;
						if (month_inc > MONTH_DEC) begin
							next_date.month = MONTH_JAN;
							next_date.year  = (state_q.year >= YEAR_MAX) ? '0 :
							                  state_q.year + 14'd1;
						end else begin
							next_date.month = month_inc;
						end
					end else begin
						next_date.day = day_inc[DAY_W-1:0];
					end
				end else begin
					next_date.hour = hour_inc[HOUR_W-1:0];
				end
			end else begin
				next_date.minute = min_sum[MINUTE_W-1:0];
			end
			mark_c = FIVE_MASK[next_date.minute];
		end
	end

	// Clock state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.year   <= YEAR_RESET;
			state_q.month  <= MONTH_JAN;
			state_q.day    <= DAY_FIRST;
			state_q.hour   <= '0;
			state_q.minute <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q <= next_date;
			end
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 2: shifted year for the weekday formula and its century
	assign yadj_c    = date_s1.year + YEAR_OFFSET - {13'd0, date_s1.month < MONTH_MAR};
	assign cent_prod = PROD_W'(yadj_c) * PROD_W'(DIV100_MUL);

	// Stage 3: weekday as a sum reduced mod 7 by octal digit folding
	always_comb begin
		rem_c   = 7'(yadj_s2 - YEAR_W'(cent_s2) * CENTURY);
		dow_sum = SUM_W'(date_s2.day) + SUM_W'(month_wday_offset(date_s2.month))
		        + (SUM_W'(cent_s2) << 2) + SUM_W'(cent_s2) + SUM_W'(cent_s2 >> 2)
		        + SUM_W'(rem_c) + SUM_W'(rem_c >> 2);
		fold1   = 5'(dow_sum[9]) + 5'(dow_sum[8:6]) + 5'(dow_sum[5:3]) + 5'(dow_sum[2:0]);
		fold2   = 4'(fold1[4:3]) + 4'(fold1[2:0]);
		dow_c   = (fold2 >= DAYS_PER_WEEK) ? 3'(fold2 - DAYS_PER_WEEK) : fold2[2:0];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			date_s1   <= next_date;
			rolled_s1 <= rolled_c;
			mark_s1   <= mark_c;
		end
		if (en_s2) begin
			date_s2   <= date_s1;
			rolled_s2 <= rolled_s1;
			mark_s2   <= mark_s1;
			yadj_s2   <= yadj_c;
			cent_s2   <= cent_prod[DIV100_SHIFT +: CENT_W];
		end
		if (en_s3) begin
			date_s3    <= date_s2;
			rolled_s3  <= rolled_s2;
			mark_s3    <= mark_s2;
			weekday_s3 <= dow_c + 3'd1;
		end
	end

	assign out_valid        = valid_s3;
	assign cur_year         = date_s3.year;
	assign cur_month        = date_s3.month;
	assign cur_day          = date_s3.day;
	assign cur_hour         = date_s3.hour;
	assign cur_minute       = date_s3.minute;
	assign weekday          = weekday_s3;
	assign day_rolled       = rolled_s3;
	assign five_minute_mark = mark_s3;

	// Checks
	a_state_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hour <= HOUR_MAX && state_q.minute <= MINUTE_MAX &&
		state_q.month >= MONTH_JAN && state_q.month <= MONTH_DEC)
		else $error("clock state out of range");

	a_s1_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> date_s1 == state_q)
		else $error("stage 1 date differs from clock state");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted transaction lost at stage 1");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weekday != 3'd0)
		else $error("weekday zero on output");

	a_roll_at_midnight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && day_rolled |-> cur_hour == '0 && cur_minute < MINS_PER_HOUR)
		else $error("day rollover without midnight hour");

endmodule

// ===== tb/sv/calendar_clock_counter_checker.sv =====
module calendar_clock_counter_checker
	import calclk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                cmd,
	input  logic [MINUTE_W-1:0] minutes_to_add,
	input  logic [YEAR_W-1:0]   set_year,
	input  logic [MONTH_W-1:0]  set_month,
	input  logic [DAY_W-1:0]    set_day,
	input  logic [HOUR_W-1:0]   set_hour,
	input  logic [MINUTE_W-1:0] set_minute,

	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [YEAR_W-1:0]   cur_year,
	input  logic [MONTH_W-1:0]  cur_month,
	input  logic [DAY_W-1:0]    cur_day,
	input  logic [HOUR_W-1:0]   cur_hour,
	input  logic [MINUTE_W-1:0] cur_minute,
	input  logic [WDAY_W-1:0]   weekday,
	input  logic                day_rolled,
	input  logic                five_minute_mark,

	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [WDAY_W-1:0]   wday;
		logic                rolled;
		logic                mark;
	} clock_reading_t;

	// Predicted clock state
	logic [YEAR_W-1:0]   year_q;
	logic [MONTH_W-1:0]  month_q;
	logic [DAY_W-1:0]    day_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [WDAY_W-1:0]   wday_q;

	clock_reading_t expected_readings[$];
	clock_reading_t want;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Larsson's formula, Jan/Feb as months 13/14 of the prior year; +400 keeps it positive
	function automatic logic [WDAY_W-1:0] weekday_of(input int day, input int month,
		input int year);
		int m;
		int y;
		int s;
		m = month;
		y = year + 400;
		if (m < 3) begin
			m += 12;
			y -= 1;
		end
		s = day + 2 * m + (3 * (m + 1)) / 5 + y + y / 4 + y / 400 - y / 100;
		return WDAY_W'(s % 7 + 1);
	endfunction

	// Apply one transaction to the predicted state and return the reading it yields
	function automatic clock_reading_t step_calendar(
		input logic                c,
		input logic [MINUTE_W-1:0] add,
		input logic [YEAR_W-1:0]   ld_year,
		input logic [MONTH_W-1:0]  ld_month,
		input logic [DAY_W-1:0]    ld_day,
		input logic [HOUR_W-1:0]   ld_hour,
		input logic [MINUTE_W-1:0] ld_minute
	);
		clock_reading_t r;
		int y;
		int mo;
		int d;
		int h;
		int mi;
		int len;
		r.rolled = 1'b0;
		r.mark   = 1'b0;
		if (c) begin
			// load: clamp each field into range, an over-long day is kept
			y  = int'(ld_year);
			mo = int'(ld_month);
			d  = int'(ld_day);
			h  = int'(ld_hour);
			mi = int'(ld_minute);
			if (y > 9999) y = 9999;
			if (mo < 1) mo = 1;
			if (mo > 12) mo = 12;
			if (d < 1) d = 1;
			if (h > 23) h = 23;
			if (mi > 59) mi = 59;
			year_q   = YEAR_W'(y);
			month_q  = MONTH_W'(mo);
			day_q    = DAY_W'(d);
			hour_q   = HOUR_W'(h);
			minute_q = MINUTE_W'(mi);
			wday_q   = weekday_of(d, mo, y);
		end else begin
			mi = int'(add);
			if (mi > 59) mi = 59;
			mi += int'(minute_q);
			if (mi % 5 == 0) r.mark = 1'b1;
			if (mi >= 60) begin
				mi -= 60;
				h = int'(hour_q) + 1;
				if (h >= 24) begin
					h = 0;
					r.rolled = 1'b1;
					// next day, with month and year carry
					y  = int'(year_q);
					mo = int'(month_q);
					d  = int'(day_q) + 1;
					if (mo == 4 || mo == 6 || mo == 9 || mo == 11) len = 30;
					else if (mo == 2) len = (y % 4 == 0) ? 29 : 28;
					else len = 31;
					if (d > len) begin
						d = 1;
						mo += 1;
						if (mo > 12) begin
							mo = 1;
							y  = (y >= 9999) ? 0 : y + 1;
						end
					end
					year_q  = YEAR_W'(y);
					month_q = MONTH_W'(mo);
					day_q   = DAY_W'(d);
					wday_q  = weekday_of(d, mo, y);
				end
				hour_q = HOUR_W'(h);
			end
			minute_q = MINUTE_W'(mi);
		end
		r.year   = year_q;
		r.month  = month_q;
		r.day    = day_q;
		r.hour   = hour_q;
		r.minute = minute_q;
		r.wday   = wday_q;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
		input logic [15:0] exp_val);
		if (got !== exp_val) begin
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp_val));
		end
	endtask

	// Watch both channels: check results against the oldest prediction, queue new ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q   = YEAR_RESET;
			month_q  = MONTH_JAN;
			day_q    = DAY_FIRST;
			hour_q   = '0;
			minute_q = '0;
			wday_q   = WDAY_RESET;
			expected_readings.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("result %0d-%0d-%0d %0d:%0d with none pending",
						cur_year, cur_month, cur_day, cur_hour, cur_minute));
				end else begin
					want = expected_readings.pop_front();
					compare_field("cur_year", 16'(cur_year), 16'(want.year));
					compare_field("cur_month", 16'(cur_month), 16'(want.month));
					compare_field("cur_day", 16'(cur_day), 16'(want.day));
					compare_field("cur_hour", 16'(cur_hour), 16'(want.hour));
					compare_field("cur_minute", 16'(cur_minute), 16'(want.minute));
					compare_field("weekday", 16'(weekday), 16'(want.wday));
					compare_field("day_rolled", 16'(day_rolled), 16'(want.rolled));
					compare_field("five_minute_mark", 16'(five_minute_mark), 16'(want.mark));
				end
			end
			if (in_valid && !in_stall) begin
				expected_readings.push_back(step_calendar(cmd, minutes_to_add, set_year,
					set_month, set_day, set_hour, set_minute));
			end
			pending <= expected_readings.size();
		end
	end

endmodule

// ===== tb/sv/calendar_clock_counter_core_tb.sv =====
module calendar_clock_counter_core_tb;
	import calclk_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 200;
	localparam int HOLD_AFTER   = 400;
	localparam int DRAIN_CYCLES = 12;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_stall;
	logic                cmd            = 1'b0;
	logic [MINUTE_W-1:0] minutes_to_add = '0;
	logic [YEAR_W-1:0]   set_year       = '0;
	logic [MONTH_W-1:0]  set_month      = '0;
	logic [DAY_W-1:0]    set_day        = '0;
	logic [HOUR_W-1:0]   set_hour       = '0;
	logic [MINUTE_W-1:0] set_minute     = '0;
	logic                out_valid;
	logic                out_stall      = 1'b0;
	logic [YEAR_W-1:0]   cur_year;
	logic [MONTH_W-1:0]  cur_month;
	logic [DAY_W-1:0]    cur_day;
	logic [HOUR_W-1:0]   cur_hour;
	logic [MINUTE_W-1:0] cur_minute;
	logic [WDAY_W-1:0]   weekday;
	logic                day_rolled;
	logic                five_minute_mark;

	int fail_count;
	int pending;
	int items_offered = 0;
	int burst_left    = 0;
	int idle_cycles   = 0;

	calendar_clock_counter_core dut (.*);

	calendar_clock_counter_checker u_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: end the run if no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("** calendar_clock_counter_core: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Receiver: stall segments of varying density, plus one long hold-off
	initial begin
		int  stall_pct;
		int  seg_len;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_offered >= HOLD_AFTER) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				held = 1'b1;
			end else begin
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 25;
					2:       stall_pct = 50;
					default: stall_pct = 80;
				endcase
				seg_len = $urandom_range(8, 64);
				repeat (seg_len) begin
					@(negedge clk);
					out_stall <= ($urandom_range(0, 99) < stall_pct);
				end
			end
		end
	end

	// Offer one transaction at a falling edge, hold it until accepted, then maybe idle
	task automatic offer_item(
		input logic                c,
		input logic [MINUTE_W-1:0] add,
		input logic [YEAR_W-1:0]   y,
		input logic [MONTH_W-1:0]  mo,
		input logic [DAY_W-1:0]    d,
		input logic [HOUR_W-1:0]   h,
		input logic [MINUTE_W-1:0] mi
	);
		in_valid       <= 1'b1;
		cmd            <= c;
		minutes_to_add <= add;
		set_year       <= y;
		set_month      <= mo;
		set_day        <= d;
		set_hour       <= h;
		set_minute     <= mi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_offered++;
		@(negedge clk);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 160)
				: $urandom_range(1, 16);
		end
	endtask

	// Set fields are don't-care on an advance, and minutes_to_add on a load
	task automatic advance_clock(input int minutes);
		offer_item(1'b0, MINUTE_W'(minutes), YEAR_W'($urandom), MONTH_W'($urandom),
			DAY_W'($urandom), HOUR_W'($urandom), MINUTE_W'($urandom));
	endtask

	task automatic load_clock(input int y, input int mo, input int d, input int h,
		input int mi);
		offer_item(1'b1, MINUTE_W'($urandom), YEAR_W'(y), MONTH_W'(mo), DAY_W'(d),
			HOUR_W'(h), MINUTE_W'(mi));
	endtask

	initial begin
		int pick;
		burst_left = $urandom_range(1, 16);
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Minute carry and the five-minute flag from the reset state
		advance_clock(0);
		advance_clock(59);
		advance_clock(1);
		// oversized increments count as 59
		advance_clock(63);
		advance_clock(60);
		// last minute of year 9999 wraps to year 0
		load_clock(9999, 12, 31, 23, 59);
		advance_clock(1);
		// every load field beyond its range
		load_clock(16383, 0, 0, 31, 63);
		load_clock(2000, 15, 31, 0, 0);
		// leap February, and the plain divisible-by-4 rule in 1900
		load_clock(2024, 2, 28, 23, 59);
		advance_clock(1);
		load_clock(2024, 2, 29, 23, 59);
		advance_clock(1);
		load_clock(2023, 2, 28, 23, 58);
		advance_clock(2);
		load_clock(1900, 2, 28, 23, 59);
		advance_clock(1);
		// day past month end rolls to the first of the next month
		load_clock(2021, 4, 31, 23, 30);
		advance_clock(30);
		load_clock(9999, 2, 29, 23, 59);
		advance_clock(59);
		// November into December
		load_clock(2023, 11, 30, 23, 55);
		advance_clock(5);
		load_clock(2023, 2, 31, 12, 0);
		advance_clock(0);
		load_clock(0, 1, 1, 0, 0);

		// Random part: mostly advances and near-midnight loads to exercise carries
		repeat (RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if ($urandom_range(0, 9) == 0) advance_clock($urandom_range(60, 63));
				else advance_clock($urandom_range(0, 59));
			end else if (pick < 75) begin
				load_clock(($urandom_range(0, 9) == 0) ? 9999 : $urandom_range(0, 9999),
					$urandom_range(1, 12), $urandom_range(27, 31), $urandom_range(22, 23),
					$urandom_range(30, 59));
			end else if (pick < 92) begin
				load_clock($urandom_range(0, 9999), $urandom_range(1, 12),
					$urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59));
			end else begin
				load_clock($urandom_range(0, 16383), $urandom_range(0, 15),
					$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63));
			end
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then a few quiet cycles
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("** calendar_clock_counter_core: PASSED **");
		end else begin
			$display("** calendar_clock_counter_core: FAILED **");
		end
		$finish;
	end

endmodule

// ===== calendar_clock_counter_core.f =====
src/calclk_pkg.sv
src/calendar_clock_counter_core.sv
tb/sv/calendar_clock_counter_checker.sv
tb/sv/calendar_clock_counter_core_tb.sv
